// File: rtl/flvdmx_pkg.sv
// flvdmx_pkg: types and constants shared by the tag body demux
// parse phases, unit kinds, parser state and transaction records
// no dependencies
`default_nettype none

package flvdmx_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 3;
    localparam int MSG_W     = 2;
    localparam int IDX_W     = 4;
    localparam int UNITS_W   = 5;
    localparam int LEN_W     = 32;
    localparam int S_USER_W  = 3;
    localparam int M_USER_W  = 6;

    localparam logic [MSG_W-1:0]  MSG_VIDEO = 2'd1;
    localparam logic [MSG_W-1:0]  MSG_AUDIO = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SPS   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PPS   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IDR   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_AINFO = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ADATA = 3'd5;

    localparam logic [BYTE_W-1:0] KEYFRAME_AVC = 8'h17;
    localparam logic [BYTE_W-1:0] AAC_MONO     = 8'hAE;
    localparam logic [UNITS_W-1:0] COUNT_MASK  = 5'h1F;

    localparam logic [IDX_W-1:0] IDX_FIRST     = 4'd1;
    localparam logic [IDX_W-1:0] IDX_VHDR_DONE = 4'd2;
    localparam logic [IDX_W-1:0] IDX_FRMLEN    = 4'd4;
    localparam logic [IDX_W-1:0] IDX_LEN_AT    = 4'd5;
    localparam logic [IDX_W-1:0] IDX_SPS_CNT   = 4'd10;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_VHDR    = 4'd1,
        PH_SEQPRE  = 4'd2,
        PH_LENHI   = 4'd3,
        PH_LENLO   = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_PPSCNT  = 4'd6,
        PH_DONE    = 4'd7,
        PH_AHDR    = 4'd8,
        PH_ADATA   = 4'd9,
        PH_FRMPRE  = 4'd10,
        PH_FRMLEN  = 4'd11
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [IDX_W-1:0]    header_index;
        logic [UNITS_W-1:0]  units_left;
        logic                in_pps_list;
        logic [LEN_W-1:0]    length_left;
        logic [KIND_W-1:0]   current_kind;
        logic                stereo_flag;
        logic                keyframe;
    } parse_state_t;

    typedef struct packed {
        logic [MSG_W-1:0]  message_kind;
        logic [BYTE_W-1:0] body_byte;
        logic              first_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] unit_kind;
        logic              stereo;
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_valid;
        logic              unit_last;
        logic              truncated;
    } out_item_t;

    localparam parse_state_t STATE_RESET = '{
        phase:        PH_IDLE,
        header_index: '0,
        units_left:   '0,
        in_pps_list:  1'b0,
        length_left:  '0,
        current_kind: KIND_SPS,
        stereo_flag:  1'b0,
        keyframe:     1'b0
    };

endpackage

`default_nettype wire

// File: rtl/flvdmx_step.sv
// flvdmx_step: next-state and result logic for one body byte
// depends on flvdmx_pkg
`default_nettype none

module flvdmx_step (
    input  flvdmx_pkg::parse_state_t st,
    input  flvdmx_pkg::in_item_t     item,
    output flvdmx_pkg::parse_state_t st_next,
    output logic                     res_vld,
    output flvdmx_pkg::out_item_t    res
);
    import flvdmx_pkg::*;

    logic [UNITS_W-1:0] units_dec;
    phase_t             finish_phase;
    logic [IDX_W-1:0]   idx_inc;
    logic [LEN_W-1:0]   len_dec;
    logic [15:0]        len16;
    logic [LEN_W-1:0]   len_frm;
    logic               emit;
    logic               e_valid;
    logic               e_last;
    logic               e_trunc;
    logic [BYTE_W-1:0]  b;
    logic               lb;

    assign b         = item.body_byte;
    assign lb        = item.last_byte;
    assign units_dec = st.units_left - UNITS_W'(1);
    assign idx_inc   = st.header_index + IDX_W'(1);
    assign len_dec   = st.length_left - LEN_W'(1);
    assign len16     = {st.length_left[7:0], b};
    assign len_frm   = {st.length_left[LEN_W-9:0], b};

    always_comb begin
        priority if (units_dec != '0) begin
            finish_phase = PH_LENHI;
        end else if (!st.in_pps_list) begin
            finish_phase = PH_PPSCNT;
        end else begin
            finish_phase = PH_DONE;
        end
    end

    always_comb begin
        st_next = st;
        emit    = 1'b0;
        e_valid = 1'b0;
        e_last  = 1'b0;
        e_trunc = 1'b0;
        if (item.first_byte) begin
            st_next              = STATE_RESET;
            st_next.keyframe     = (b == KEYFRAME_AVC);
            st_next.stereo_flag  = (b != AAC_MONO);
            st_next.header_index = IDX_FIRST;
            if (!lb && item.message_kind == MSG_VIDEO) begin
                st_next.phase = PH_VHDR;
            end else if (!lb && item.message_kind == MSG_AUDIO) begin
                st_next.phase = PH_AHDR;
            end
        end else begin
            unique case (st.phase)
                PH_VHDR: begin
                    st_next.header_index = IDX_VHDR_DONE;
                    if (b == '0) begin
                        st_next.current_kind = KIND_SPS;
                        st_next.phase        = PH_SEQPRE;
                    end else begin
                        st_next.current_kind = st.keyframe ? KIND_IDR : KIND_OTHER;
                        st_next.phase        = PH_FRMPRE;
                    end
                end
                PH_SEQPRE: begin
                    if (st.header_index == IDX_SPS_CNT) begin
                        st_next.units_left  = b[UNITS_W-1:0] & COUNT_MASK;
                        st_next.in_pps_list = 1'b0;
                        st_next.phase = (b[UNITS_W-1:0] != '0) ? PH_LENHI : PH_PPSCNT;
                    end else begin
                        st_next.header_index = idx_inc;
                    end
                end
                PH_PPSCNT: begin
                    st_next.units_left   = b[UNITS_W-1:0] & COUNT_MASK;
                    st_next.in_pps_list  = 1'b1;
                    st_next.current_kind = KIND_PPS;
                    st_next.phase = (b[UNITS_W-1:0] != '0) ? PH_LENHI : PH_DONE;
                end
                PH_LENHI: begin
                    st_next.length_left = LEN_W'(b);
                    st_next.phase       = PH_LENLO;
                end
                PH_LENLO: begin
                    st_next.length_left = LEN_W'(len16);
                    if (len16 == '0) begin
                        emit               = 1'b1;
                        e_last             = 1'b1;
                        st_next.units_left = units_dec;
                        st_next.phase      = finish_phase;
                    end else begin
                        st_next.phase = PH_PAYLOAD;
                    end
                end
                PH_FRMPRE: begin
                    if (st.header_index == IDX_LEN_AT) begin
                        st_next.length_left  = LEN_W'(b);
                        st_next.header_index = IDX_FIRST;
                        st_next.units_left   = UNITS_W'(1);
                        st_next.in_pps_list  = 1'b1;
                        st_next.phase        = PH_FRMLEN;
                    end else begin
                        st_next.header_index = idx_inc;
                    end
                end
                PH_FRMLEN: begin
                    st_next.length_left  = len_frm;
                    st_next.header_index = idx_inc;
                    if (idx_inc >= IDX_FRMLEN) begin
                        if (len_frm == '0) begin
                            emit               = 1'b1;
                            e_last             = 1'b1;
                            st_next.units_left = units_dec;
                            st_next.phase      = finish_phase;
                        end else begin
                            st_next.phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    st_next.length_left = len_dec;
                    emit    = 1'b1;
                    e_valid = 1'b1;
                    if (len_dec == '0) begin
                        e_last             = 1'b1;
                        st_next.units_left = units_dec;
                        st_next.phase      = finish_phase;
                    end else begin
                        e_last  = lb;
                        e_trunc = lb;
                    end
                end
                PH_AHDR: begin
                    st_next.current_kind = (b == '0) ? KIND_AINFO : KIND_ADATA;
                    st_next.phase        = PH_ADATA;
                    if (lb) begin
                        emit   = 1'b1;
                        e_last = 1'b1;
                    end
                end
                PH_ADATA: begin
                    emit    = 1'b1;
                    e_valid = 1'b1;
                    e_last  = lb;
                end
                default: begin
                end
            endcase
            if (lb) begin
                if (!emit && (st_next.phase == PH_LENLO || st_next.phase == PH_FRMLEN)) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    e_trunc = 1'b1;
                end
                st_next.phase = PH_IDLE;
            end
        end
    end

    always_comb begin
        res_vld          = emit;
        res.unit_kind    = st_next.current_kind;
        res.stereo       = (st_next.current_kind == KIND_AINFO ||
                            st_next.current_kind == KIND_ADATA) ? st_next.stereo_flag : 1'b0;
        res.payload_byte = e_valid ? b : '0;
        res.byte_valid   = e_valid;
        res.unit_last    = e_last;
        res.truncated    = e_trunc;
    end

endmodule

`default_nettype wire

// File: rtl/flv_avc_aac_tag_body_demux.sv
// flv_avc_aac_tag_body_demux: splits media message bodies into sps/pps/nalu/aac units
// depends on flvdmx_pkg and flvdmx_step
//
//  channel  dir  tdata          tuser                                       tlast
//  s_       in   body_byte      message_kind[1:0], first_byte[2]            last_byte
//  m_       out  payload_byte   unit_kind[2:0], stereo[3], byte_valid[4],   unit_last
//                               truncated[5]
//
// one body byte per cycle unless m_ stalls; the result is registered after the input register
// the parser state sits between an input register and a result register;
// the per-byte step is a 32-bit decrement and compare plus selection
// aresetn clears control and parser state, no sweep
// a stalled m_ side holds the step; s_tready stays high while a result
// waits if the input register is empty
`default_nettype none

module flv_avc_aac_tag_body_demux (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [flvdmx_pkg::BYTE_W-1:0]      s_tdata,   // body_byte
    input  wire logic [flvdmx_pkg::S_USER_W-1:0]    s_tuser,   // message_kind, first_byte
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [flvdmx_pkg::BYTE_W-1:0]           m_tdata,   // payload_byte
    output logic [flvdmx_pkg::M_USER_W-1:0]         m_tuser,   // unit_kind, stereo, byte_valid, truncated
    output logic                                    m_tlast
);
    import flvdmx_pkg::*;

    logic         in_vld_reg;
    in_item_t     in_item_reg;
    logic         out_vld_reg;
    out_item_t    out_item_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         res_vld;
    out_item_t    res;
    logic         advance;

    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;

    flvdmx_step u_step (
        .st      (state_reg),
        .item    (in_item_reg),
        .st_next (state_next),
        .res_vld (res_vld),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= STATE_RESET;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg && res_vld;
                if (in_vld_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_item_reg.message_kind <= s_tuser[MSG_W-1:0];
            in_item_reg.first_byte   <= s_tuser[MSG_W];
            in_item_reg.body_byte    <= s_tdata;
            in_item_reg.last_byte    <= s_tlast;
        end
        if (advance && in_vld_reg && res_vld) begin
            out_item_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_item_reg.payload_byte;
    assign m_tuser  = {out_item_reg.truncated, out_item_reg.byte_valid,
                       out_item_reg.stereo, out_item_reg.unit_kind};
    assign m_tlast  = out_item_reg.unit_last;

    a_empty_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[4] |-> m_tdata == '0)
        else $error("empty marker carries payload bits");

    a_trunc_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[5] |-> m_tlast)
        else $error("truncated transaction not marked last");

    a_stereo_audio_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |->
            (m_tuser[2:0] == KIND_AINFO || m_tuser[2:0] == KIND_ADATA))
        else $error("stereo flag on a video unit");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && advance && in_item_reg.last_byte |=> state_reg.phase == PH_IDLE)
        else $error("parser not idle after last body byte");

endmodule

`default_nettype wire

// File: sim/tb_flv_avc_aac_tag_body_demux.sv
// tb_flv_avc_aac_tag_body_demux: random and directed media message bodies into the tag body
// demux, each unit byte on the m_ side checked against an in-bench parser model
// depends on flvdmx_pkg and flv_avc_aac_tag_body_demux
`default_nettype none

module tb_flv_avc_aac_tag_body_demux;
    timeunit 1ns;
    timeprecision 1ps;

    import flvdmx_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BODY_ITEMS  = 225;

    class flv_unit_scoreboard;
        phase_t             phase;
        logic [IDX_W-1:0]   hdr_idx;
        logic [UNITS_W-1:0] units_left;
        bit                 in_pps;
        logic [LEN_W-1:0]   len_left;
        logic [KIND_W-1:0]  kind;
        bit                 stereo;
        logic [BYTE_W-1:0]  first_b;
        out_item_t          expected_q[$];
        int                 errors;

        function new();
            clear_body();
            errors = 0;
        endfunction

        function void clear_body();
            phase      = PH_IDLE;
            hdr_idx    = '0;
            units_left = '0;
            in_pps     = 1'b0;
            len_left   = '0;
            kind       = KIND_SPS;
            stereo     = 1'b0;
            first_b    = '0;
        endfunction

        function void emit(logic [BYTE_W-1:0] b, bit valid, bit last, bit trunc);
            out_item_t e;
            e.unit_kind    = kind;
            e.stereo       = (kind == KIND_AINFO || kind == KIND_ADATA) ? stereo : 1'b0;
            e.payload_byte = valid ? b : '0;
            e.byte_valid   = valid;
            e.unit_last    = last;
            e.truncated    = trunc;
            expected_q.push_back(e);
        endfunction

        function void close_unit();
            units_left = units_left - 1'b1;
            if (units_left != 0) begin
                phase = PH_LENHI;
            end else if (!in_pps) begin
                phase = PH_PPSCNT;
            end else begin
                phase = PH_DONE;
            end
        endfunction

        function void note_body_byte(in_item_t it);
            logic [BYTE_W-1:0] b;
            bit                lb;
            bit                produced;
            b        = it.body_byte;
            lb       = it.last_byte;
            produced = 1'b0;
            if (it.first_byte) begin
                clear_body();
                first_b = b;
                stereo  = (b != AAC_MONO);
                hdr_idx = IDX_FIRST;
                if (!lb && it.message_kind == MSG_VIDEO) begin
                    phase = PH_VHDR;
                end else if (!lb && it.message_kind == MSG_AUDIO) begin
                    phase = PH_AHDR;
                end
                return;
            end
            case (phase)
                PH_VHDR: begin
                    hdr_idx = IDX_VHDR_DONE;
                    if (b == 8'h00) begin
                        kind  = KIND_SPS;
                        phase = PH_SEQPRE;
                    end else begin
                        kind  = (first_b == KEYFRAME_AVC) ? KIND_IDR : KIND_OTHER;
                        phase = PH_FRMPRE;
                    end
                end
                PH_SEQPRE: begin
                    if (hdr_idx == IDX_SPS_CNT) begin
                        units_left = b[UNITS_W-1:0];
                        in_pps     = 1'b0;
                        if (units_left != 0) begin
                            phase = PH_LENHI;
                        end else begin
                            phase = PH_PPSCNT;
                        end
                    end else begin
                        hdr_idx = hdr_idx + 1'b1;
                    end
                end
                PH_PPSCNT: begin
                    units_left = b[UNITS_W-1:0];
                    in_pps     = 1'b1;
                    kind       = KIND_PPS;
                    if (units_left != 0) begin
                        phase = PH_LENHI;
                    end else begin
                        phase = PH_DONE;
                    end
                end
                PH_LENHI: begin
                    len_left = {24'd0, b};
                    phase    = PH_LENLO;
                end
                PH_LENLO: begin
                    len_left = {16'd0, len_left[7:0], b};
                    if (len_left == 0) begin
                        emit(8'h00, 1'b0, 1'b1, 1'b0);
                        produced = 1'b1;
                        close_unit();
                    end else begin
                        phase = PH_PAYLOAD;
                    end
                end
                PH_FRMPRE: begin
                    if (hdr_idx == IDX_LEN_AT) begin
                        len_left   = {24'd0, b};
                        hdr_idx    = IDX_FIRST;
                        units_left = 5'd1;
                        in_pps     = 1'b1;
                        phase      = PH_FRMLEN;
                    end else begin
                        hdr_idx = hdr_idx + 1'b1;
                    end
                end
                PH_FRMLEN: begin
                    len_left = {len_left[23:0], b};
                    hdr_idx  = hdr_idx + 1'b1;
                    if (hdr_idx >= IDX_FRMLEN) begin
                        if (len_left == 0) begin
                            emit(8'h00, 1'b0, 1'b1, 1'b0);
                            produced = 1'b1;
                            close_unit();
                        end else begin
                            phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    len_left = len_left - 1'b1;
                    if (len_left == 0) begin
                        emit(b, 1'b1, 1'b1, 1'b0);
                        close_unit();
                    end else begin
                        emit(b, 1'b1, lb, lb);
                    end
                    produced = 1'b1;
                end
                PH_AHDR: begin
                    kind  = (b == 8'h00) ? KIND_AINFO : KIND_ADATA;
                    phase = PH_ADATA;
                    if (lb) begin
                        emit(8'h00, 1'b0, 1'b1, 1'b0);
                        produced = 1'b1;
                    end
                end
                PH_ADATA: begin
                    emit(b, 1'b1, lb, 1'b0);
                    produced = 1'b1;
                end
                default: begin
                end
            endcase
            if (lb) begin
                if (!produced && (phase == PH_LENLO || phase == PH_FRMLEN)) begin
                    emit(8'h00, 1'b0, 1'b1, 1'b1);
                end
                phase = PH_IDLE;
            end
        endfunction

        function void check_unit_byte(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected unit byte: kind %0d stereo %0d byte %02h valid %0d",
                         $time, got.unit_kind, got.stereo, got.payload_byte, got.byte_valid,
                         " last %0d trunc %0d", got.unit_last, got.truncated);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got !== e) begin
                $display("%0t: unit byte mismatch: expected kind %0d stereo %0d byte %02h",
                         $time, e.unit_kind, e.stereo, e.payload_byte,
                         " valid %0d last %0d trunc %0d", e.byte_valid, e.unit_last, e.truncated);
                $display("%0t:                      got kind %0d stereo %0d byte %02h",
                         $time, got.unit_kind, got.stereo, got.payload_byte,
                         " valid %0d last %0d trunc %0d", got.byte_valid, got.unit_last,
                         got.truncated);
                errors++;
            end
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic              m_tlast;

    flv_avc_aac_tag_body_demux i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    flv_unit_scoreboard sb = new();
    int                 s_idle_pct = 32;
    int                 m_idle_pct = 46;
    int                 cycles     = 0;
    int                 body_count = 0;
    logic [BYTE_W-1:0]  body[$];
    in_item_t           mon_in;
    out_item_t          mon_out;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    // result transactions are checked before the input transaction of the same edge is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                mon_out.unit_kind    = m_tuser[2:0];
                mon_out.stereo       = m_tuser[3];
                mon_out.payload_byte = m_tdata;
                mon_out.byte_valid   = m_tuser[4];
                mon_out.unit_last    = m_tlast;
                mon_out.truncated    = m_tuser[5];
                sb.check_unit_byte(mon_out);
            end
            if (s_tvalid && s_tready) begin
                mon_in.message_kind = s_tuser[1:0];
                mon_in.body_byte    = s_tdata;
                mon_in.first_byte   = s_tuser[2];
                mon_in.last_byte    = s_tlast;
                sb.note_body_byte(mon_in);
            end
        end
    end

    task automatic send_byte(logic [MSG_W-1:0] kind, logic [BYTE_W-1:0] b, bit fb, bit lb);
        @(negedge aclk);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = {fb, kind};
        s_tlast  = lb;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_body(logic [MSG_W-1:0] kind, bit closed);
        for (int i = 0; i < body.size(); i++) begin
            send_byte(kind, body[i], i == 0, closed && i == body.size() - 1);
        end
        if (kind == MSG_VIDEO || kind == MSG_AUDIO) begin
            body_count += body.size();
        end
    endtask

    task automatic send_stray(int n);
        for (int i = 0; i < n; i++) begin
            send_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0,
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    // pushes a 16- or 32-bit length and payload, above 24 bytes cut short; returns 0 if cut
    function automatic bit add_unit(int len_bytes, logic [31:0] len);
        int n;
        for (int i = len_bytes - 1; i >= 0; i--) begin
            body.push_back(len[8*i +: 8]);
        end
        n = (len > 24) ? $urandom_range(1, 24) : len;
        for (int i = 0; i < n; i++) begin
            body.push_back(8'($urandom_range(0, 255)));
        end
        return n == len;
    endfunction

    function automatic void build_seq_header();
        logic [31:0] len;
        int          cnt;
        body = {};
        body.push_back($urandom_range(0, 3) != 0 ? KEYFRAME_AVC : 8'($urandom_range(0, 255)));
        body.push_back(8'h00);
        for (int i = 2; i < 10; i++) begin
            body.push_back(8'($urandom_range(0, 255)));
        end
        for (int list = 0; list < 2; list++) begin
            cnt = $urandom_range(0, 3);
            body.push_back({3'($urandom_range(0, 7)), 5'(cnt)});
            for (int u = 0; u < cnt; u++) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 6);
                if (!add_unit(2, len)) begin
                    return;
                end
            end
        end
        for (int i = $urandom_range(0, 3) - 2; i > 0; i--) begin
            body.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void build_frame();
        logic [31:0] len;
        body = {};
        case ($urandom_range(0, 2))
            0: body.push_back(KEYFRAME_AVC);
            1: body.push_back(8'h27);
            default: body.push_back(8'($urandom_range(0, 255)));
        endcase
        body.push_back(8'($urandom_range(1, 255)));
        for (int i = 2; i < 5; i++) begin
            body.push_back(8'($urandom_range(0, 255)));
        end
        len = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 12);
        if (add_unit(4, len)) begin
            for (int i = $urandom_range(0, 5) - 2; i > 0; i--) begin
                body.push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    function automatic void build_audio();
        int n;
        body = {};
        case ($urandom_range(0, 2))
            0: body.push_back(AAC_MONO);
            1: body.push_back(8'hAF);
            default: body.push_back(8'($urandom_range(0, 255)));
        endcase
        body.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
            body.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic random_bodies(int target);
        logic [MSG_W-1:0] kind;
        int               sel;
        int               n;
        int               stop;
        stop = body_count + target;
        while (body_count < stop) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                build_seq_header();
                kind = MSG_VIDEO;
            end else if (sel < 60) begin
                build_frame();
                kind = MSG_VIDEO;
            end else if (sel < 85) begin
                build_audio();
                kind = MSG_AUDIO;
            end else begin
                kind = 2'($urandom_range(0, 3));
                n    = $urandom_range(1, 8);
                body = {};
                for (int i = 0; i < n; i++) begin
                    body.push_back(8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, body.size());
                while (body.size() > n) void'(body.pop_back());
            end
            send_body(kind, $urandom_range(0, 19) != 0);
            if ($urandom_range(0, 9) == 0) begin
                send_stray($urandom_range(1, 3));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // sequence header: masked sps count, zero-length pps, trailing byte
        body = '{8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h64, 8'h00, 8'h1F, 8'hFF,
                 8'hE1, 8'h00, 8'h03, 8'h67, 8'hAA, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h5A};
        send_body(MSG_VIDEO, 1'b1);
        // idr frame then a stray byte
        body = '{8'h17, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h65, 8'h88};
        send_body(MSG_VIDEO, 1'b1);
        send_stray(1);
        // zero-length frame with trailing byte
        body = '{8'h27, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_body(MSG_VIDEO, 1'b1);
        // frame cut inside its payload
        body = '{8'h27, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h11, 8'h22};
        send_body(MSG_VIDEO, 1'b1);
        // frame cut inside its length
        body = '{8'h27, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12};
        send_body(MSG_VIDEO, 1'b1);
        // sequence header cut inside an sps length
        body = '{8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h64, 8'h00, 8'h1F, 8'hFF,
                 8'h01, 8'h00};
        send_body(MSG_VIDEO, 1'b1);
        // sequence header cut inside its payload, full 16-bit length
        body = '{8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h64, 8'h00, 8'h1F, 8'hFF,
                 8'h01, 8'hFF, 8'hFF, 8'h80, 8'h7F};
        send_body(MSG_VIDEO, 1'b1);
        // empty sps and pps lists
        body = '{8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h64, 8'h00, 8'h1F, 8'hFF,
                 8'h00, 8'h00};
        send_body(MSG_VIDEO, 1'b1);
        // short header
        body = '{8'h17, 8'h00, 8'h00, 8'h00};
        send_body(MSG_VIDEO, 1'b1);
        body = '{8'hAE, 8'h00, 8'h12, 8'h10};
        send_body(MSG_AUDIO, 1'b1);
        body = '{8'hAF, 8'h01, 8'hFF, 8'h00, 8'h80};
        send_body(MSG_AUDIO, 1'b1);
        body = '{8'hAF, 8'h01};
        send_body(MSG_AUDIO, 1'b1);
        body = '{8'h17};
        send_body(MSG_VIDEO, 1'b1);
        body = '{8'hAF, 8'h01, 8'h33};
        send_body(2'd0, 1'b1);
        send_body(2'd3, 1'b1);
        // audio body abandoned by a new first byte
        send_body(MSG_AUDIO, 1'b0);
        body = '{8'hAE, 8'h01, 8'h44};
        send_body(MSG_AUDIO, 1'b1);

        random_bodies(BODY_ITEMS);
        drain_results();
        s_idle_pct = 46;
        m_idle_pct = 32;
        random_bodies(BODY_ITEMS);
        drain_results();
        s_idle_pct = 0;
        m_idle_pct = 0;
        random_bodies(BODY_ITEMS);
        drain_results();
        repeat (20) @(posedge aclk);

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
